@@ rtl/bfpr_pkg.sv @@
// Shared types and constants of the boundary-first point renumbering unit.
// No dependencies; bfpr_clear, bfpr_update and the top level import this package.
`default_nettype none

package bfpr_pkg;

  // Field widths of the item and result ports.
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 12;
  localparam int COUNT_W = 13;
  localparam int NUM_W   = 12;

  // Default map depth.
  localparam int MAX_POINTS_DEF = 4096;

  // Largest value a count register can hold.
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Item commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_BOUNDARY = 2'd1,
    CMD_INTERNAL = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_t;

  // One accepted item.
  typedef struct packed {
    cmd_t             cmd;
    logic [IDX_W-1:0] idx;
  } item_t;

  // One entry of the point map.
  typedef struct packed {
    logic             valid;
    logic             boundary;
    logic [NUM_W-1:0] number;
  } map_entry_t;

  localparam int ENTRY_W = $bits(map_entry_t);

  // Map write request from the update stage.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    map_entry_t       data;
  } upd_wr_t;

  // One result item.
  typedef struct packed {
    logic               mapped;
    logic [IDX_W-1:0]   new_index;
    logic               ordered;
    logic [COUNT_W-1:0] icount;
    logic               error;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/bfpr_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; a read during a write to the same address returns old data.
`default_nettype none

module bfpr_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/bfpr_clear.sv @@
// Clearing sequencer: walks the whole point map once after reset and after a clear.
// Depends on bfpr_pkg for the default depth MAX_POINTS_DEF.
`default_nettype none

module bfpr_clear import bfpr_pkg::*; #(
  parameter int DEPTH = MAX_POINTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     kick,
  output      logic                     sweeping,
  output      logic [$clog2(DEPTH)-1:0] addr
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  // One entry per cycle, from address zero to the last entry.
  always_ff @(posedge clk) begin
    if (rst || kick) begin
      sweeping <= 1'b1;
      addr     <= '0;
    end else if (sweeping) begin
      addr <= addr + AW'(1);
      if (addr == LAST) begin
        sweeping <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/bfpr_update.sv @@
// Update stage: decides the new map entry, the counters and the result of one item.
// Depends on bfpr_pkg for the item, entry, write and result types.
`default_nettype none

module bfpr_update import bfpr_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [COUNT_W-1:0] point_count,
  input  wire logic               stage_valid,
  input  wire item_t              stage_item,
  input  wire map_entry_t         entry,
  output      upd_wr_t            wr,
  output      logic               done,
  output      result_t            res
);

  localparam logic [COUNT_W-1:0] MAX_CLIP =
    (MAX_POINTS > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(MAX_POINTS);

  logic [COUNT_W-1:0] boundary_seen, boundary_seen_next;
  logic [COUNT_W-1:0] internal_seen, internal_seen_next;
  logic               ordered_flag, ordered_flag_next;
  logic               internal_phase, internal_phase_next;
  result_t            res_next;

  logic [COUNT_W-1:0] eff_count;
  logic [COUNT_W-1:0] icount;
  logic [COUNT_W-1:0] icount_after;
  logic [COUNT_W-1:0] idx_ext;
  logic               is_clear;
  logic               err;
  logic               new_b;
  logic               new_i;
  map_entry_t         sel;

  // Effective point count and the internal count before this item.
  always_comb begin
    eff_count = (point_count > MAX_CLIP) ? MAX_CLIP : point_count;
    icount    = (boundary_seen > eff_count) ? '0 : eff_count - boundary_seen;
    idx_ext   = COUNT_W'(stage_item.idx);
  end

  // Classification of the item and the map write it causes.
  always_comb begin
    is_clear = stage_item.cmd == CMD_CLEAR;
    err      = !is_clear && ((idx_ext >= eff_count) ||
               (stage_item.cmd == CMD_BOUNDARY && internal_phase));
    new_b    = stage_valid && !is_clear && !err &&
               stage_item.cmd == CMD_BOUNDARY && !entry.valid;
    new_i    = stage_valid && !is_clear && !err &&
               stage_item.cmd == CMD_INTERNAL && !entry.valid;

    wr.en   = new_b || new_i;
    wr.addr = stage_item.idx;
    wr.data.valid    = 1'b1;
    wr.data.boundary = new_b;
    wr.data.number   = new_b ? boundary_seen[NUM_W-1:0] : internal_seen[NUM_W-1:0];
  end

  // Next counters, flags and the result item.
  always_comb begin
    boundary_seen_next  = boundary_seen;
    internal_seen_next  = internal_seen;
    ordered_flag_next   = ordered_flag;
    internal_phase_next = internal_phase;
    icount_after        = icount;
    sel                 = entry;
    res_next            = res;

    if (new_b) begin
      boundary_seen_next = boundary_seen + COUNT_W'(1);
      icount_after       = (icount == '0) ? '0 : icount - COUNT_W'(1);
    end
    if (new_i) begin
      internal_seen_next = internal_seen + COUNT_W'(1);
      if (idx_ext >= icount) begin
        ordered_flag_next = 1'b0;
      end
    end
    if (stage_valid && !is_clear && !err && stage_item.cmd == CMD_INTERNAL) begin
      internal_phase_next = 1'b1;
    end
    if (wr.en) begin
      sel = wr.data;
    end

    if (stage_valid) begin
      if (is_clear) begin
        boundary_seen_next  = '0;
        internal_seen_next  = '0;
        ordered_flag_next   = 1'b1;
        internal_phase_next = 1'b0;
        res_next.mapped     = 1'b0;
        res_next.new_index  = '0;
        res_next.ordered    = 1'b1;
        res_next.icount     = eff_count;
        res_next.error      = 1'b0;
      end else begin
        res_next.mapped    = !err && sel.valid;
        res_next.new_index = '0;
        if (!err && sel.valid) begin
          res_next.new_index = sel.boundary ?
                               sel.number + icount_after[NUM_W-1:0] : sel.number;
        end
        res_next.ordered = ordered_flag_next;
        res_next.icount  = icount_after;
        res_next.error   = err;
      end
    end
  end

  // State registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      boundary_seen  <= '0;
      internal_seen  <= '0;
      ordered_flag   <= 1'b1;
      internal_phase <= 1'b0;
      done           <= 1'b0;
    end else begin
      boundary_seen  <= boundary_seen_next;
      internal_seen  <= internal_seen_next;
      ordered_flag   <= ordered_flag_next;
      internal_phase <= internal_phase_next;
      done           <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

`default_nettype wire

@@ rtl/boundary_first_point_renumbering_unit.sv @@
// Boundary-first point renumbering unit: point map RAM, clearing sequencer, update stage.
// Depends on bfpr_pkg, bfpr_ram, bfpr_clear and bfpr_update.
// An accepted item is registered in the item stage together with its map read; the
// update stage then registers done and the result, which the receiver takes.
// Throughput: one item per cycle while busy is low; map reads and writes to one entry
// are forwarded. A clear item blocks new items from staging through the clearing pass.
// Reset starts the same clearing pass over the whole map; point_count resets to zero.
// The receiver cannot stall: each result is on the ports for the single cycle of done.
`default_nettype none

module boundary_first_point_renumbering_unit import bfpr_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic [CMD_W-1:0]   command,
  input  wire logic [IDX_W-1:0]   point_index,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [COUNT_W-1:0] cfg_data,
  output      logic               done,
  output      logic               mapped,
  output      logic [IDX_W-1:0]   new_index,
  output      logic               ordered,
  output      logic [COUNT_W-1:0] internal_point_count,
  output      logic               error
);

  localparam int AW = $clog2(MAX_POINTS);

  logic [COUNT_W-1:0] point_count;
  logic               stage_valid;
  item_t              stage_item;
  logic [AW-1:0]      stage_addr;
  logic               accept;
  logic               sweeping;
  logic [AW-1:0]      sweep_addr;
  logic               kick;
  upd_wr_t            upd_wr;
  result_t            res;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  map_entry_t         ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               fwd_en;
  logic [AW-1:0]      fwd_addr;
  map_entry_t         fwd_data;
  map_entry_t         entry;

  // Handshake: hold off items during a clear and its pass.
  assign kick      = stage_valid && stage_item.cmd == CMD_CLEAR;
  assign busy      = sweeping || kick;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      point_count <= cfg_data;
    end
  end

  // Item stage, aligned with the map read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    stage_item.cmd <= cmd_t'(command);
    stage_item.idx <= point_index;
    stage_addr     <= AW'(point_index);
  end

  // Map write port: the clearing pass or the update stage.
  always_comb begin
    if (sweeping) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = upd_wr.en;
      ram_waddr = AW'(upd_wr.addr);
      ram_wdata = upd_wr.data;
    end
  end

  // The write of the previous edge is not yet in the read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_en <= 1'b0;
    end else begin
      fwd_en <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= ram_waddr;
    fwd_data <= ram_wdata;
  end

  assign entry = (fwd_en && fwd_addr == stage_addr) ? fwd_data : map_entry_t'(ram_rdata);

  bfpr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(point_index)),
    .rdata (ram_rdata)
  );

  bfpr_clear #(
    .DEPTH (MAX_POINTS)
  ) u_clear (
    .clk      (clk),
    .rst      (rst),
    .kick     (kick),
    .sweeping (sweeping),
    .addr     (sweep_addr)
  );

  bfpr_update #(
    .MAX_POINTS (MAX_POINTS)
  ) u_update (
    .clk         (clk),
    .rst         (rst),
    .point_count (point_count),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .entry       (entry),
    .wr          (upd_wr),
    .done        (done),
    .res         (res)
  );

  // Result ports.
  assign mapped               = res.mapped;
  assign new_index            = res.new_index;
  assign ordered              = res.ordered;
  assign internal_point_count = res.icount;
  assign error                = res.error;

  // The update stage never writes the map while the clearing pass owns it.
  a_no_upd_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    upd_wr.en |-> !sweeping)
    else $error("map update during clearing pass");

  // Every staged item yields exactly one result in the next cycle.
  a_done_follows_stage: assert property (@(posedge clk) disable iff (rst)
    stage_valid |=> done)
    else $error("staged item produced no result");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |=> !done)
    else $error("result without a staged item");

  // A clear item starts the clearing pass on the following cycle.
  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    kick |=> sweeping && !stage_valid)
    else $error("clear did not start the clearing pass");

  // A refused item never reports a mapping.
  a_error_unmapped: assert property (@(posedge clk) disable iff (rst)
    done && error |-> !mapped && new_index == '0)
    else $error("refused item reported a mapping");

endmodule

`default_nettype wire
